[sv/psa_pkg.sv]
// Shared types and constants of the priority scheduler with aging.
package psa_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int TIME_BITS_DEF = 16;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_START = 2'd1,
      ACT_ROUND = 2'd2,
      ACT_OTHER = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      EV_ACK  = 2'd0,
      EV_IDLE = 2'd1,
      EV_RAN  = 2'd2,
      EV_DONE = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      PH_NEW   = 2'd0,
      PH_READY = 2'd1,
      PH_RUN   = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_START, ST_ACK, ST_CHECK, ST_ADMIT, ST_PICK,
      ST_SEL, ST_EXEC, ST_WAIT, ST_FIN, ST_PICK2, ST_PRE
   } state_type;

   typedef enum logic [3:0] {
      OP_NOP, OP_CAPTURE, OP_LOAD, OP_START, OP_ACK, OP_CHECK, OP_ADMIT,
      OP_PICK, OP_SEL, OP_EXEC, OP_WAIT, OP_FIN, OP_PRE
   } op_type;

   localparam logic [1:0] REG_PREEMPT = 2'd0;
   localparam logic [1:0] REG_AGING   = 2'd1;
   localparam logic [1:0] REG_LIMIT   = 2'd2;
   localparam logic [1:0] REG_SWITCH  = 2'd3;

   typedef struct packed {
      logic        preempt_mode;
      logic        aging_on;
      logic [15:0] aging_limit;
      logic [7:0]  switch_cost;
   } cfg_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       done_all;
      logic       run_vld;
      logic       scan_last;
      logic       sweep_last;
      logic       found;
      logic       left_zero;
      logic       preempt_mode;
   } status_type;

endpackage

[sv/psa_ctrl.sv]
// Controller state machine sequencing load, start and scheduling rounds.
module psa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  psa_pkg::status_type sts,
   output psa_pkg::cmd_type    cmd
);

   psa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != psa_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = psa_pkg::OP_NOP;
      case (state_ff)
         psa_pkg::ST_IDLE: begin
            if (start) begin
               cmd.op   = psa_pkg::OP_CAPTURE;
               state_in = psa_pkg::ST_DECODE;
            end
         end
         psa_pkg::ST_DECODE: begin
            case (sts.action)
               psa_pkg::ACT_LOAD: begin
                  cmd.op   = psa_pkg::OP_LOAD;
                  state_in = psa_pkg::ST_IDLE;
               end
               psa_pkg::ACT_START: state_in = psa_pkg::ST_START;
               psa_pkg::ACT_ROUND: state_in = psa_pkg::ST_CHECK;
               default: begin
                  cmd.op   = psa_pkg::OP_ACK;
                  state_in = psa_pkg::ST_IDLE;
               end
            endcase
         end
         psa_pkg::ST_START: begin
            cmd.op = psa_pkg::OP_START;
            if (sts.sweep_last) state_in = psa_pkg::ST_ACK;
         end
         psa_pkg::ST_ACK: begin
            cmd.op   = psa_pkg::OP_ACK;
            state_in = psa_pkg::ST_IDLE;
         end
         psa_pkg::ST_CHECK: begin
            cmd.op   = psa_pkg::OP_CHECK;
            state_in = sts.done_all ? psa_pkg::ST_IDLE : psa_pkg::ST_ADMIT;
         end
         psa_pkg::ST_ADMIT: begin
            cmd.op = psa_pkg::OP_ADMIT;
            if (sts.scan_last) state_in = sts.run_vld ? psa_pkg::ST_EXEC : psa_pkg::ST_PICK;
         end
         psa_pkg::ST_PICK: begin
            cmd.op = psa_pkg::OP_PICK;
            if (sts.scan_last) state_in = psa_pkg::ST_SEL;
         end
         psa_pkg::ST_SEL: begin
            cmd.op   = psa_pkg::OP_SEL;
            state_in = sts.found ? psa_pkg::ST_EXEC : psa_pkg::ST_IDLE;
         end
         psa_pkg::ST_EXEC: begin
            cmd.op   = psa_pkg::OP_EXEC;
            state_in = psa_pkg::ST_WAIT;
         end
         psa_pkg::ST_WAIT: begin
            cmd.op = psa_pkg::OP_WAIT;
            if (sts.scan_last) state_in = psa_pkg::ST_FIN;
         end
         psa_pkg::ST_FIN: begin
            cmd.op = psa_pkg::OP_FIN;
            state_in = (sts.left_zero || !sts.preempt_mode) ? psa_pkg::ST_IDLE
                                                             : psa_pkg::ST_PICK2;
         end
         psa_pkg::ST_PICK2: begin
            cmd.op = psa_pkg::OP_PICK;
            if (sts.scan_last) state_in = psa_pkg::ST_PRE;
         end
         psa_pkg::ST_PRE: begin
            cmd.op   = psa_pkg::OP_PRE;
            state_in = psa_pkg::ST_IDLE;
         end
         default: state_in = psa_pkg::ST_IDLE;
      endcase
   end

endmodule

[sv/psa_dp.sv]
// Datapath: task table, scan index, time, best-pick tracking and result registers.
module psa_dp #(
   parameter int MAX_TASKS = psa_pkg::MAX_TASKS_DEF,
   parameter int TIME_BITS = psa_pkg::TIME_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  psa_pkg::cmd_type    cmd,
   output psa_pkg::status_type sts,
   input  psa_pkg::cfg_type    cfg,
   input  logic [1:0]          req_action,
   input  logic [3:0]          req_slot,
   input  logic [15:0]         req_arrive_at,
   input  logic [15:0]         req_burst_len,
   input  logic [7:0]          req_prio_value,
   input  logic                req_is_last_slot,
   output logic                rsp_valid,
   output logic [1:0]          rsp_event_res,
   output logic [3:0]          rsp_ran_slot,
   output logic [15:0]         rsp_seg_start,
   output logic [15:0]         rsp_seg_end,
   output logic                rsp_finished,
   output logic [15:0]         rsp_turnaround,
   output logic [15:0]         rsp_waited,
   output logic [15:0]         rsp_response,
   output logic [15:0]         rsp_switch_count
);

   localparam int TB = TIME_BITS;
   localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = SW + 5;

   function automatic logic [15:0] t16(input logic [TB-1:0] v);
      logic [TB+15:0] x;
      x = {{16{1'b0}}, v};
      return x[15:0];
   endfunction

   function automatic logic [TB-1:0] ttb(input logic [15:0] v);
      logic [TB+15:0] x;
      x = {{TB{1'b0}}, v};
      return x[TB-1:0];
   endfunction

   function automatic logic [TB-1:0] sat(input logic [TB-1:0] a, input logic [TB-1:0] b);
      logic [TB:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TB] ? {TB{1'b1}} : s[TB-1:0];
   endfunction

   function automatic logic [TB-1:0] diff0(input logic [TB-1:0] a, input logic [TB-1:0] b);
      return (a >= b) ? (a - b) : '0;
   endfunction

   function automatic logic [3:0] s4(input logic [SW-1:0] v);
      logic [SW+3:0] x;
      x = {4'b0000, v};
      return x[3:0];
   endfunction

   // task table
   logic [TB-1:0]      arr_ff   [MAX_TASKS];
   logic [TB-1:0]      burst_ff [MAX_TASKS];
   logic [7:0]         prio_ff  [MAX_TASKS];
   logic [TB-1:0]      left_ff  [MAX_TASKS];
   psa_pkg::phase_type phase_ff [MAX_TASKS];
   logic               started_ff [MAX_TASKS];
   logic [TB-1:0]      resp_ff  [MAX_TASKS];
   logic [TB-1:0]      wait_ff  [MAX_TASKS];
   logic [TB-1:0]      stamp_ff [MAX_TASKS];
   logic               svld_ff  [MAX_TASKS];

   // captured transaction
   psa_pkg::action_type act_ff;
   logic [3:0]  slot_ff;
   logic [15:0] arrive_ff, burst_in_ff;
   logic [7:0]  prio_in_ff;
   logic        last_slot_ff;

   logic [SW-1:0] idx_ff, idx_in;
   logic [TB-1:0] now_ff, now_in;
   logic          run_vld_ff, run_vld_in;
   logic [SW-1:0] run_ff, run_in;
   logic          last_vld_ff, last_vld_in;
   logic [SW-1:0] last_ff, last_in;
   logic [15:0]   pre_ff, pre_in;
   logic [4:0]    done_ff, done_in;
   logic [4:0]    total_ff, total_in;
   logic          found_ff, found_in;
   logic [SW-1:0] best_ff, best_in;
   logic [7:0]    bprio_ff, bprio_in;
   logic [TB-1:0] barr_ff, barr_in;
   logic [TB-1:0] actual_ff, actual_in;
   logic [TB-1:0] segs_ff, segs_in;
   logic [7:0]    cprio_ff, cprio_in;

   logic          valid_ff;
   psa_pkg::event_type ev_ff;
   logic [3:0]    oslot_ff;
   logic [15:0]   ostart_ff, oend_ff, oturn_ff, owait_ff, oresp_ff, osc_ff;
   logic          ofin_ff;

   // entry write
   logic               e_we, e_tw;
   logic [SW-1:0]      ra;
   logic [TB-1:0]      e_arr, e_burst, e_left, e_resp, e_wait, e_stamp;
   logic [7:0]         e_prio;
   psa_pkg::phase_type e_phase;
   logic               e_started, e_svld;

   // emitted fields
   logic               emit;
   psa_pkg::event_type em_ev;
   logic [3:0]         em_slot;
   logic [15:0]        em_start, em_end, em_turn, em_wait, em_resp;
   logic               em_fin;

   logic [CW-1:0] total_ext, n_ext, idx_ext, slot_ext, run_ext;
   logic          slot_ok, cand, better, fnd, age_hit;
   logic [TB-1:0] r_arr, r_burst, r_left, r_wait, r_stamp, r_resp, st, act;
   logic [7:0]    r_prio;
   psa_pkg::phase_type r_phase, ph;

   assign total_ext = {{SW{1'b0}}, total_ff};
   assign n_ext     = (total_ext < CW'(MAX_TASKS)) ? total_ext : CW'(MAX_TASKS);
   assign idx_ext   = {5'b00000, idx_ff};
   assign run_ext   = {5'b00000, run_ff};
   assign slot_ext  = {{(SW+1){1'b0}}, slot_ff};
   assign slot_ok   = slot_ext < CW'(MAX_TASKS);

   always_comb begin
      case (cmd.op)
         psa_pkg::OP_LOAD: ra = slot_ext[SW-1:0];
         psa_pkg::OP_SEL:  ra = best_ff;
         psa_pkg::OP_EXEC, psa_pkg::OP_FIN, psa_pkg::OP_PRE: ra = run_ff;
         default: ra = idx_ff;
      endcase
   end

   assign r_arr     = arr_ff[ra];
   assign r_burst   = burst_ff[ra];
   assign r_prio    = prio_ff[ra];
   assign r_left    = left_ff[ra];
   assign r_phase   = phase_ff[ra];
   assign r_wait    = wait_ff[ra];
   assign r_stamp   = stamp_ff[ra];
   assign r_resp    = resp_ff[ra];

   assign cand   = (r_phase == psa_pkg::PH_READY) && (r_arr <= now_ff);
   assign fnd    = (idx_ff != '0) && found_ff;
   assign better = cand && (!fnd || (r_prio < bprio_ff) ||
                            ((r_prio == bprio_ff) && (r_arr < barr_ff)));

   assign sts.action       = act_ff;
   assign sts.done_all     = (done_ff >= total_ff);
   assign sts.run_vld      = run_vld_ff;
   assign sts.scan_last    = (idx_ext == (n_ext - CW'(1)));
   assign sts.sweep_last   = (idx_ext == CW'(MAX_TASKS - 1));
   assign sts.found        = found_ff;
   assign sts.left_zero    = (r_left == '0);
   assign sts.preempt_mode = cfg.preempt_mode;

   always_comb begin
      idx_in = idx_ff; now_in = now_ff; run_vld_in = run_vld_ff; run_in = run_ff;
      last_vld_in = last_vld_ff; last_in = last_ff; pre_in = pre_ff;
      done_in = done_ff; total_in = total_ff; found_in = found_ff; best_in = best_ff;
      bprio_in = bprio_ff; barr_in = barr_ff; actual_in = actual_ff; segs_in = segs_ff;
      cprio_in = cprio_ff;
      e_we = 1'b0; e_tw = 1'b0;
      e_arr = r_arr; e_burst = r_burst; e_prio = r_prio; e_left = r_left;
      e_phase = r_phase; e_started = started_ff[ra]; e_resp = r_resp;
      e_wait = r_wait; e_stamp = r_stamp; e_svld = svld_ff[ra];
      emit = 1'b0; em_ev = psa_pkg::EV_ACK; em_slot = '0; em_start = '0; em_end = '0;
      em_fin = 1'b0; em_turn = '0; em_wait = '0; em_resp = '0;
      ph = r_phase; st = r_stamp; act = '0; age_hit = 1'b0;
      case (cmd.op)
         psa_pkg::OP_CAPTURE: idx_in = '0;
         psa_pkg::OP_LOAD: begin
            emit = 1'b1;
            if (slot_ok) begin
               e_tw    = 1'b1;
               e_arr   = ttb(arrive_ff);
               e_burst = ttb(burst_in_ff);
               e_prio  = prio_in_ff;
               if (last_slot_ff) total_in = 5'(slot_ff) + 5'd1;
            end
         end
         psa_pkg::OP_START: begin
            if (idx_ff == '0) begin
               now_in = '0; run_vld_in = 1'b0; last_vld_in = 1'b0;
               pre_in = '0; done_in = '0;
            end
            e_we = 1'b1;
            e_left = r_burst;
            e_phase = (r_arr == '0) ? psa_pkg::PH_READY : psa_pkg::PH_NEW;
            e_started = 1'b0; e_resp = '0; e_wait = '0; e_stamp = '0; e_svld = 1'b0;
            idx_in = sts.sweep_last ? '0 : idx_ff + SW'(1);
         end
         psa_pkg::OP_ACK: emit = 1'b1;
         psa_pkg::OP_CHECK: begin
            idx_in = '0;
            if (sts.done_all) begin
               emit = 1'b1; em_ev = psa_pkg::EV_DONE;
            end else if (run_vld_ff && (run_ext >= n_ext)) begin
               run_vld_in = 1'b0;
            end
         end
         psa_pkg::OP_ADMIT: begin
            if ((ph == psa_pkg::PH_NEW) && (r_arr <= now_ff)) ph = psa_pkg::PH_READY;
            e_we = 1'b1;
            e_phase = ph;
            if (cfg.aging_on && (ph == psa_pkg::PH_READY)) begin
               st = svld_ff[ra] ? r_stamp : now_ff;
               age_hit = ({{16{1'b0}}, diff0(now_ff, st)} >= {{TB{1'b0}}, cfg.aging_limit})
                         && (r_prio != '0);
               if (age_hit) begin
                  e_prio = r_prio - 8'd1;
                  st = now_ff;
               end
               e_stamp = st;
               e_svld = 1'b1;
            end
            idx_in = sts.scan_last ? '0 : idx_ff + SW'(1);
         end
         psa_pkg::OP_PICK: begin
            found_in = fnd | cand;
            if (better) begin
               best_in = idx_ff; bprio_in = r_prio; barr_in = r_arr;
            end
            idx_in = sts.scan_last ? '0 : idx_ff + SW'(1);
         end
         psa_pkg::OP_SEL: begin
            if (found_ff) begin
               run_in = best_ff; run_vld_in = 1'b1;
               e_we = 1'b1;
               e_phase = psa_pkg::PH_RUN;
               if (!started_ff[ra]) begin
                  e_resp = diff0(now_ff, r_arr);
                  e_started = 1'b1;
               end
               if (last_vld_ff && (last_ff != best_ff))
                  now_in = sat(now_ff, ttb({8'h00, cfg.switch_cost}));
               e_svld = 1'b0;
            end else begin
               now_in = sat(now_ff, TB'(1));
               emit = 1'b1; em_ev = psa_pkg::EV_IDLE;
               em_start = t16(now_ff); em_end = t16(now_in);
            end
         end
         psa_pkg::OP_EXEC: begin
            act = cfg.preempt_mode ? ((r_left != '0) ? TB'(1) : '0) : r_left;
            e_we = 1'b1;
            e_left = r_left - act;
            actual_in = act;
            segs_in = now_ff;
            now_in = sat(now_ff, act);
            last_in = run_ff; last_vld_in = 1'b1;
            cprio_in = r_prio;
         end
         psa_pkg::OP_WAIT: begin
            if (cand) begin
               e_we = 1'b1;
               e_wait = sat(r_wait, actual_ff);
            end
            idx_in = sts.scan_last ? '0 : idx_ff + SW'(1);
         end
         psa_pkg::OP_FIN: begin
            em_ev = psa_pkg::EV_RAN; em_slot = s4(run_ff);
            em_start = t16(segs_ff); em_end = t16(now_ff);
            if (r_left == '0) begin
               e_we = 1'b1; e_phase = psa_pkg::PH_DONE;
               done_in = done_ff + 5'd1; run_vld_in = 1'b0;
               emit = 1'b1; em_fin = 1'b1;
               em_turn = t16(diff0(now_ff, r_arr));
               em_wait = t16(r_wait); em_resp = t16(r_resp);
            end else if (!cfg.preempt_mode) begin
               emit = 1'b1;
            end
         end
         psa_pkg::OP_PRE: begin
            em_ev = psa_pkg::EV_RAN; em_slot = s4(run_ff);
            em_start = t16(segs_ff); em_end = t16(now_ff);
            emit = 1'b1;
            if (found_ff && (best_ff != run_ff) && (bprio_ff < cprio_ff)) begin
               e_we = 1'b1; e_phase = psa_pkg::PH_READY;
               pre_in = (pre_ff == 16'hFFFF) ? pre_ff : pre_ff + 16'd1;
               run_vld_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (e_tw) begin
         arr_ff[ra]   <= e_arr;
         burst_ff[ra] <= e_burst;
      end
      if (e_tw || e_we) prio_ff[ra] <= e_prio;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            left_ff[i] <= '0; phase_ff[i] <= psa_pkg::PH_NEW; started_ff[i] <= 1'b0;
            resp_ff[i] <= '0; wait_ff[i] <= '0; stamp_ff[i] <= '0; svld_ff[i] <= 1'b0;
         end
      end else if (e_we) begin
         left_ff[ra] <= e_left; phase_ff[ra] <= e_phase; started_ff[ra] <= e_started;
         resp_ff[ra] <= e_resp; wait_ff[ra] <= e_wait; stamp_ff[ra] <= e_stamp;
         svld_ff[ra] <= e_svld;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == psa_pkg::OP_CAPTURE) begin
         act_ff <= psa_pkg::action_type'(req_action);
         slot_ff <= req_slot; arrive_ff <= req_arrive_at; burst_in_ff <= req_burst_len;
         prio_in_ff <= req_prio_value; last_slot_ff <= req_is_last_slot;
      end
      best_ff <= best_in; bprio_ff <= bprio_in; barr_ff <= barr_in;
      actual_ff <= actual_in; segs_ff <= segs_in; cprio_ff <= cprio_in;
      run_ff <= run_in; last_ff <= last_in;
      if (emit) begin
         ev_ff <= em_ev; oslot_ff <= em_slot; ostart_ff <= em_start; oend_ff <= em_end;
         ofin_ff <= em_fin; oturn_ff <= em_turn; owait_ff <= em_wait;
         oresp_ff <= em_resp; osc_ff <= pre_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0; now_ff <= '0; run_vld_ff <= 1'b0; last_vld_ff <= 1'b0;
         pre_ff <= '0; done_ff <= '0; total_ff <= '0; found_ff <= 1'b0; valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in; now_ff <= now_in; run_vld_ff <= run_vld_in;
         last_vld_ff <= last_vld_in; pre_ff <= pre_in; done_ff <= done_in;
         total_ff <= total_in; found_ff <= found_in; valid_ff <= emit;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_event_res    = ev_ff;
   assign rsp_ran_slot     = oslot_ff;
   assign rsp_seg_start    = ostart_ff;
   assign rsp_seg_end      = oend_ff;
   assign rsp_finished     = ofin_ff;
   assign rsp_turnaround   = oturn_ff;
   assign rsp_waited       = owait_ff;
   assign rsp_response     = oresp_ff;
   assign rsp_switch_count = osc_ff;

endmodule

[sv/priority_scheduler_with_aging_top.sv]
// Top level: configuration registers, controller and datapath of the scheduler.
// A transaction is taken when start is high and busy is low; busy drops in the cycle in which
// its single result is strobed on rsp_valid, and the receiver must take the result in that
// cycle, as it cannot stall. A start resets the whole task table, one entry per cycle. A round
// that does not find all tasks done walks the task table one slot per cycle in up to four
// passes (admit and age, pick, waiting update, preemption pick) over the n loaded task slots.
module priority_scheduler_with_aging_top #(
   parameter int MAX_TASKS = psa_pkg::MAX_TASKS_DEF,
   parameter int TIME_BITS = psa_pkg::TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_slot,
   input  logic [15:0] req_arrive_at,
   input  logic [15:0] req_burst_len,
   input  logic [7:0]  req_prio_value,
   input  logic        req_is_last_slot,
   output logic        rsp_valid,
   output logic [1:0]  rsp_event_res,
   output logic [3:0]  rsp_ran_slot,
   output logic [15:0] rsp_seg_start,
   output logic [15:0] rsp_seg_end,
   output logic        rsp_finished,
   output logic [15:0] rsp_turnaround,
   output logic [15:0] rsp_waited,
   output logic [15:0] rsp_response,
   output logic [15:0] rsp_switch_count,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   psa_pkg::cfg_type    cfg_ff, cfg_in;
   psa_pkg::cmd_type    cmd;
   psa_pkg::status_type sts;
   logic                wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (paddr[3:2])
            psa_pkg::REG_PREEMPT: cfg_in.preempt_mode = pwdata[0];
            psa_pkg::REG_AGING:   cfg_in.aging_on     = pwdata[0];
            psa_pkg::REG_LIMIT:   cfg_in.aging_limit  = pwdata[15:0];
            psa_pkg::REG_SWITCH:  cfg_in.switch_cost  = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{preempt_mode: 1'b0, aging_on: 1'b0, aging_limit: 16'd10,
                     switch_cost: 8'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         psa_pkg::REG_PREEMPT: prdata = {31'd0, cfg_ff.preempt_mode};
         psa_pkg::REG_AGING:   prdata = {31'd0, cfg_ff.aging_on};
         psa_pkg::REG_LIMIT:   prdata = {16'd0, cfg_ff.aging_limit};
         psa_pkg::REG_SWITCH:  prdata = {24'd0, cfg_ff.switch_cost};
         default:              prdata = '0;
      endcase
   end

   psa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   psa_dp #(
      .MAX_TASKS (MAX_TASKS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .cfg              (cfg_ff),
      .req_action       (req_action),
      .req_slot         (req_slot),
      .req_arrive_at    (req_arrive_at),
      .req_burst_len    (req_burst_len),
      .req_prio_value   (req_prio_value),
      .req_is_last_slot (req_is_last_slot),
      .rsp_valid        (rsp_valid),
      .rsp_event_res    (rsp_event_res),
      .rsp_ran_slot     (rsp_ran_slot),
      .rsp_seg_start    (rsp_seg_start),
      .rsp_seg_end      (rsp_seg_end),
      .rsp_finished     (rsp_finished),
      .rsp_turnaround   (rsp_turnaround),
      .rsp_waited       (rsp_waited),
      .rsp_response     (rsp_response),
      .rsp_switch_count (rsp_switch_count)
   );

endmodule
